>>> rtl/core/mf2d_pkg.sv
// Shared constants, register codes and types for the 2-D median filter.
package mf2d_pkg;

	localparam int PIX_W           = 8;
	localparam int OCOL_W          = 11;
	localparam int OROW_W          = 12;
	localparam int LINE_REG_W      = 12;
	localparam int ROWS_W          = 13;
	localparam int CFG_DATA_W      = 13;
	localparam int CFG_IDX_W       = 1;
	localparam int ROW_LIMIT       = 4096;
	localparam int LINE_WIDTH_RST  = 640;
	localparam int FRAME_ROWS_RST  = 480;
	localparam int WINDOW_SIZE_DEF = 3;
	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int QUEUE_DEPTH     = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH = 1'b0,
		REG_FRAME_ROWS = 1'b1
	} cfg_reg_t;

	// Per-pixel result tag built by the front end
	typedef struct packed {
		logic              emit;
		logic [OCOL_W-1:0] col;
		logic [OROW_W-1:0] row;
		logic              last;
	} res_meta_t;

endpackage

>>> rtl/core/mf2d_front.sv
// Front end: configuration registers, input beat acceptance and raster position tracking.
module mf2d_front import mf2d_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [PIX_W-1:0]          pixel_value,
	input  logic                      frame_start,
	input  logic                      q_full,
	output logic                      push,
	output logic [PIX_W-1:0]          push_px,
	output logic [$clog2(MAX_WIDTH)-1:0] push_col,
	output res_meta_t                 push_meta
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CLW   = 14;
	localparam int XW    = 14;
	localparam int W_RST = (LINE_WIDTH_RST < MAX_WIDTH) ? LINE_WIDTH_RST : MAX_WIDTH;

	logic [WW-1:0]     w_q;
	logic [ROWS_W-1:0] h_q;
	logic [CW-1:0]     col_q;
	logic [OROW_W-1:0] row_q;

	logic [CLW-1:0]    lw_ext;
	logic [ROWS_W-1:0] fr_ext;
	logic [WW-1:0]     w_new;
	logic [ROWS_W-1:0] h_new;

	logic [CW-1:0]     col_in;
	logic [OROW_W-1:0] row_in;
	logic              col_over;
	logic [CW-1:0]     c;
	logic [ROWS_W-1:0] r1;
	logic [OROW_W-1:0] r;
	logic [WW-1:0]     c_inc;
	logic [ROWS_W-1:0] r_inc;
	logic              col_wrap;
	logic              row_wrap;
	logic [XW-1:0]     oc_full;
	logic [ROWS_W-1:0] or_full;
	logic [CW-1:0]     col_nxt;
	logic [OROW_W-1:0] row_nxt;

	// Saturate written sizes to the supported range
	always_comb begin
		lw_ext = CLW'(cfg_wdata[LINE_REG_W-1:0]);
		fr_ext = cfg_wdata[ROWS_W-1:0];
		if (lw_ext < CLW'(WINDOW_SIZE)) begin
			w_new = WW'(WINDOW_SIZE);
		end else if (lw_ext > CLW'(MAX_WIDTH)) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(lw_ext);
		end
		if (fr_ext < ROWS_W'(WINDOW_SIZE)) begin
			h_new = ROWS_W'(WINDOW_SIZE);
		end else if (fr_ext > ROWS_W'(ROW_LIMIT)) begin
			h_new = ROWS_W'(ROW_LIMIT);
		end else begin
			h_new = fr_ext;
		end
	end

	// Hold effective width and row count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= ROWS_W'(FRAME_ROWS_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LINE_WIDTH: w_q <= w_new;
				REG_FRAME_ROWS: h_q <= h_new;
				default: ;
			endcase
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Place the incoming pixel and work out its result tag
	always_comb begin
		col_in   = frame_start ? '0 : col_q;
		row_in   = frame_start ? '0 : row_q;
		col_over = WW'(col_in) >= w_q;
		c        = col_over ? '0 : col_in;
		r1       = ROWS_W'(row_in) + ROWS_W'(col_over);
		r        = (r1 >= h_q) ? '0 : r1[OROW_W-1:0];
		c_inc    = WW'(c) + WW'(1);
		r_inc    = ROWS_W'(r) + ROWS_W'(1);
		col_wrap = c_inc >= w_q;
		row_wrap = r_inc >= h_q;
		oc_full  = XW'(c) - XW'(WINDOW_SIZE / 2);
		or_full  = ROWS_W'(r) - ROWS_W'(WINDOW_SIZE / 2);

		push_px        = pixel_value;
		push_col       = c;
		push_meta.emit = (WW'(c) >= WW'(WINDOW_SIZE - 1)) && (r >= OROW_W'(WINDOW_SIZE - 1));
		push_meta.col  = oc_full[OCOL_W-1:0];
		push_meta.row  = or_full[OROW_W-1:0];
		push_meta.last = col_wrap && row_wrap;

		col_nxt = col_wrap ? '0 : c_inc[CW-1:0];
		if (col_wrap) begin
			row_nxt = row_wrap ? '0 : r_inc[OROW_W-1:0];
		end else begin
			row_nxt = r;
		end
	end

	// Advance the position on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

endmodule

>>> rtl/core/mf2d_queue.sv
// Small FIFO that decouples the front end from the filter pipeline.
module mf2d_queue import mf2d_pkg::*; #(
	parameter int DW    = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          full,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [DW-1:0] data_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full  = count_q == NW'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = data_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

>>> rtl/core/mf2d_window.sv
// Line stores and the square pixel window, fed one pixel per beat.
module mf2d_window import mf2d_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        head_valid,
	input  logic [PIX_W-1:0]                            head_px,
	input  logic [$clog2(MAX_WIDTH)-1:0]                head_col,
	input  res_meta_t                                   head_meta,
	output logic                                        pop,
	output logic [WINDOW_SIZE*WINDOW_SIZE-1:0][PIX_W-1:0] win,
	output logic                                        v_s2,
	output res_meta_t                                   meta_s2
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int N  = WINDOW_SIZE * WINDOW_SIZE;
	localparam int NL = WINDOW_SIZE - 1;

	logic [NL-1:0][PIX_W-1:0] mem [MAX_WIDTH];

	logic                     v_s1;
	logic [PIX_W-1:0]         px_s1;
	logic [CW-1:0]            col_s1;
	res_meta_t                meta_s1;
	logic [NL-1:0][PIX_W-1:0] rd_s1;
	logic                     byp_s1;
	logic [NL-1:0][PIX_W-1:0] bypd_s1;

	logic [NL-1:0][PIX_W-1:0]          line_s1;
	logic [WINDOW_SIZE-1:0][PIX_W-1:0] colv;
	logic [NL-1:0][PIX_W-1:0]          wr_data;
	logic [N-1:0][PIX_W-1:0]           win_q;
	logic [N-1:0][PIX_W-1:0]           win_nxt;
	logic                              shift;

	assign pop   = en && head_valid;
	assign shift = en && v_s1;
	assign win   = win_q;

	// Form the vertical slice and the rows written back
	always_comb begin
		line_s1 = byp_s1 ? bypd_s1 : rd_s1;
		for (int k = 0; k < NL; k++) begin
			colv[k] = line_s1[k];
		end
		colv[WINDOW_SIZE-1] = px_s1;
		for (int k = 0; k < NL; k++) begin
			wr_data[k] = colv[k+1];
		end
	end

	// Line store: read on pop, write back as the pixel leaves the first stage
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s1 <= mem[head_col];
		end
		if (shift) begin
			mem[col_s1] <= wr_data;
		end
	end

	// First-stage payload; forward the write when the read hits the same column
	always_ff @(posedge clk) begin
		if (pop) begin
			px_s1   <= head_px;
			col_s1  <= head_col;
			meta_s1 <= head_meta;
			byp_s1  <= v_s1 && (head_col == col_s1);
			bypd_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= head_valid;
		end
	end

	// Shift the window left, new slice enters at the right
	always_comb begin
		for (int k = 0; k < WINDOW_SIZE; k++) begin
			for (int j = 0; j < WINDOW_SIZE - 1; j++) begin
				win_nxt[k*WINDOW_SIZE+j] = win_q[k*WINDOW_SIZE+j+1];
			end
			win_nxt[k*WINDOW_SIZE+WINDOW_SIZE-1] = colv[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			win_q <= win_nxt;
		end
	end

	// Second stage: only interior positions go on to the median
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && meta_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			meta_s2 <= meta_s1;
		end
	end

endmodule

>>> rtl/core/mf2d_median.sv
// Rank-based median of the window: compare matrix, rank match, select, output register.
module mf2d_median import mf2d_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic                                          v_s2,
	input  res_meta_t                                     meta_s2,
	input  logic [WINDOW_SIZE*WINDOW_SIZE-1:0][PIX_W-1:0] win,
	output logic                                          out_valid,
	output logic [PIX_W-1:0]                              median_value,
	output logic [OCOL_W-1:0]                             out_col,
	output logic [OROW_W-1:0]                             out_row,
	output logic                                          frame_last
);

	localparam int N   = WINDOW_SIZE * WINDOW_SIZE;
	localparam int MID = N / 2;

	logic [N-1:0][N-1:0]     cmp_nxt;
	logic [N-1:0][N-1:0]     cmp_s3;
	logic [N-1:0][PIX_W-1:0] val_s3;
	res_meta_t               meta_s3;
	logic                    v_s3;

	logic [N-1:0]            hit_nxt;
	logic [N-1:0]            hit_s4;
	logic [N-1:0][PIX_W-1:0] val_s4;
	res_meta_t               meta_s4;
	logic                    v_s4;

	logic [PIX_W-1:0]        med_sel;
	logic                    out_valid_q;
	logic [PIX_W-1:0]        median_q;
	res_meta_t               meta_q;

	// Element j counts below element i if smaller, or equal and earlier
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				if (j < i) begin
					cmp_nxt[i][j] = win[j] <= win[i];
				end else if (j > i) begin
					cmp_nxt[i][j] = win[j] < win[i];
				end else begin
					cmp_nxt[i][j] = 1'b0;
				end
			end
		end
	end

	// Mark the element whose rank is the middle one
	always_comb begin
		for (int i = 0; i < N; i++) begin
			hit_nxt[i] = $countones(cmp_s3[i]) == MID;
		end
	end

	// Pick the marked element
	always_comb begin
		med_sel = '0;
		for (int i = 0; i < N; i++) begin
			if (hit_s4[i]) begin
				med_sel = med_sel | val_s4[i];
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			cmp_s3  <= cmp_nxt;
			val_s3  <= win;
			meta_s3 <= meta_s2;
			hit_s4  <= hit_nxt;
			val_s4  <= val_s3;
			meta_s4 <= meta_s3;
		end
		if (en && v_s4) begin
			median_q <= med_sel;
			meta_q   <= meta_s4;
		end
	end

	assign out_valid    = out_valid_q;
	assign median_value = median_q;
	assign out_col      = meta_q.col;
	assign out_row      = meta_q.row;
	assign frame_last   = meta_q.last;

endmodule

>>> rtl/core/median_filter_2d.sv
// Top level of the 2-D median filter over a raster pixel stream.
//
// Input channel: in_valid / in_stall with pixel_value and frame_start; frame_start
// marks row 0, column 0 of a frame. Output channel: out_valid / out_stall with
// median_value, out_col, out_row and frame_last. Border positions give no beat.
// Configuration: cfg_we writes cfg_wdata into line_width (index 0) or frame_rows
// (index 1); sizes are saturated to WINDOW_SIZE..MAX_WIDTH and WINDOW_SIZE..4096.
// Write them only while the block is idle.
// Throughput: one pixel per cycle while out_stall does not hold the pipeline, limited
// by the line store's single read-modify-write per column. Path: after any wait in
// the 4-entry input queue, the pixel completing its window passes the first window
// stage, the window register, the compare and rank stages and the output register.
// Reset: position counters go to row 0, column 0, line_width to 640 (saturated to
// MAX_WIDTH), frame_rows to 480, window to zero; the line store is not cleared.
// Stall: while out_stall holds a waiting result, the filter pipeline freezes and
// the input queue keeps taking beats; in_stall rises once the queue is full.
module median_filter_2d import mf2d_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel_value,
	input  logic                  frame_start,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      median_value,
	output logic [OCOL_W-1:0]     out_col,
	output logic [OROW_W-1:0]     out_row,
	output logic                  frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int MW = $bits(res_meta_t);
	localparam int QW = PIX_W + CW + MW;
	localparam int N  = WINDOW_SIZE * WINDOW_SIZE;

	logic                    push;
	logic [PIX_W-1:0]        push_px;
	logic [CW-1:0]           push_col;
	res_meta_t               push_meta;
	logic [QW-1:0]           q_wdata;
	logic [QW-1:0]           q_rdata;
	logic                    q_full;
	logic                    q_empty;
	logic                    pop;
	logic [PIX_W-1:0]        head_px;
	logic [CW-1:0]           head_col;
	res_meta_t               head_meta;
	logic                    en;
	logic [N-1:0][PIX_W-1:0] win;
	logic                    v_s2;
	res_meta_t               meta_s2;

	// Pipeline moves unless a waiting result is stalled
	assign en = !out_valid || !out_stall;

	assign q_wdata                     = {push_px, push_col, push_meta};
	assign {head_px, head_col, head_meta} = q_rdata;

	mf2d_front #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.MAX_WIDTH   (MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_value (pixel_value),
		.frame_start (frame_start),
		.q_full      (q_full),
		.push        (push),
		.push_px     (push_px),
		.push_col    (push_col),
		.push_meta   (push_meta)
	);

	mf2d_queue #(
		.DW    (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	mf2d_window #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.MAX_WIDTH   (MAX_WIDTH)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.head_valid (!q_empty),
		.head_px    (head_px),
		.head_col   (head_col),
		.head_meta  (head_meta),
		.pop        (pop),
		.win        (win),
		.v_s2       (v_s2),
		.meta_s2    (meta_s2)
	);

	mf2d_median #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_median (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.v_s2         (v_s2),
		.meta_s2      (meta_s2),
		.win          (win),
		.out_valid    (out_valid),
		.median_value (median_value),
		.out_col      (out_col),
		.out_row      (out_row),
		.frame_last   (frame_last)
	);

endmodule

>>> tb/sv/tb_median_filter_2d.sv
// Self-checking testbench for the 3x3 median filter: raster pixel beats in, medians out.
`timescale 1ns / 100ps

module tb_median_filter_2d;
	import mf2d_pkg::*;

	localparam int WIN           = WINDOW_SIZE_DEF;
	localparam int IDLE_PCT      = 12;
	localparam int RANDOM_ITEMS  = 1900;
	localparam int WIDE_ITEMS    = 64;
	localparam int SETTLE_CYCLES = 20;
	localparam int STUCK_LIMIT   = 1000;
	localparam int HOLD_CYCLES   = 120;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             fs;
	} pixel_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0]  med;
		logic [OCOL_W-1:0] col;
		logic [OROW_W-1:0] row;
		logic              last;
	} median_beat_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel_value = '0;
	logic                  frame_start = 1'b0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [PIX_W-1:0]      median_value;
	logic [OCOL_W-1:0]     out_col;
	logic [OROW_W-1:0]     out_row;
	logic                  frame_last;

	// Filter state kept by the testbench
	logic [PIX_W-1:0]      line_mem [(WIN-1)*MAX_WIDTH_DEF];
	logic [PIX_W-1:0]      win_px [WIN*WIN];
	int unsigned           col_pos;
	int unsigned           row_pos;
	logic [LINE_REG_W-1:0] cfg_line_width;
	logic [ROWS_W-1:0]     cfg_frame_rows;

	pixel_beat_t  pixel_backlog [$];
	median_beat_t pending_medians [$];
	pixel_beat_t  next_beat;

	logic pix_taken = 1'b0;
	int   cyc = 0;
	int   stuck = 0;
	int   hold_left = 0;
	int   holds_done = 0;
	int   mismatches = 0;
	int   pixels_in = 0;
	int   medians_seen = 0;
	int   frame_ends = 0;
	int   cfg_writes = 0;
	int   backpressure = 0;
	bit   calm;

	assign calm = (cyc >= 2000) && (cyc < 4000);

	median_filter_2d dut (.*);

	always #5 clk = ~clk;

	function automatic int unsigned sat_width(input logic [LINE_REG_W-1:0] lw);
		int unsigned w;
		w = lw;
		if (w < WIN)
			w = WIN;
		else if (w > MAX_WIDTH_DEF)
			w = MAX_WIDTH_DEF;
		return w;
	endfunction

	function automatic int unsigned sat_rows(input logic [ROWS_W-1:0] fr);
		int unsigned h;
		h = fr;
		if (h < WIN)
			h = WIN;
		else if (h > ROW_LIMIT)
			h = ROW_LIMIT;
		return h;
	endfunction

	// Advance the window by one pixel and queue the median it completes, if any
	task automatic advance_window(input logic [PIX_W-1:0] px, input logic fs);
		int unsigned w, h, c, r;
		logic [PIX_W-1:0] slice [WIN];
		logic [PIX_W-1:0] srt [WIN*WIN];
		logic [PIX_W-1:0] v;
		median_beat_t res;
		int i, j, k;
		w = sat_width(cfg_line_width);
		h = sat_rows(cfg_frame_rows);
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		// wrap a position left beyond a lowered size
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		c = col_pos;
		r = row_pos;
		// vertical slice, oldest row first, and push the column down the line stores
		for (k = 0; k < WIN-1; k++)
			slice[k] = line_mem[k*MAX_WIDTH_DEF + c];
		slice[WIN-1] = px;
		for (k = 0; k < WIN-1; k++)
			line_mem[k*MAX_WIDTH_DEF + c] = slice[k+1];
		// shift the window left, new slice enters at the right
		for (k = 0; k < WIN; k++) begin
			for (j = 0; j < WIN-1; j++)
				win_px[k*WIN + j] = win_px[k*WIN + j + 1];
			win_px[k*WIN + WIN-1] = slice[k];
		end
		if (c >= WIN-1 && r >= WIN-1) begin
			for (i = 0; i < WIN*WIN; i++)
				srt[i] = win_px[i];
			for (i = 1; i < WIN*WIN; i++) begin
				v = srt[i];
				j = i;
				while (j > 0 && srt[j-1] > v) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = v;
			end
			res.med  = srt[(WIN*WIN)/2];
			res.col  = OCOL_W'(c - WIN/2);
			res.row  = OROW_W'(r - WIN/2);
			res.last = (c == w-1) && (r == h-1);
			pending_medians.push_back(res);
		end
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return PIX_W'($urandom_range(0, 255));
		if (sel == 6)
			return 8'h00;
		if (sel == 7)
			return 8'hFF;
		// flat region with a little noise
		return PIX_W'(120 + $urandom_range(0, 15));
	endfunction

	task automatic queue_pixel(input logic [PIX_W-1:0] px, input logic fs);
		pixel_beat_t b;
		b.pix = px;
		b.fs  = fs;
		pixel_backlog.push_back(b);
	endtask

	// Wait until every pixel is taken and every median is back, then let the pipe drain
	task automatic settle();
		@(posedge clk);
		while (pixel_backlog.size() != 0 || in_valid || pending_medians.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_LINE_WIDTH: cfg_line_width = val[LINE_REG_W-1:0];
			REG_FRAME_ROWS: cfg_frame_rows = val[ROWS_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Reconfigure while idle, then queue a run of pixels
	task automatic run_phase(input logic [CFG_DATA_W-1:0] lw, input logic [CFG_DATA_W-1:0] fr,
			input int n, input logic restart);
		settle();
		write_reg(REG_LINE_WIDTH, lw);
		write_reg(REG_FRAME_ROWS, fr);
		for (int i = 0; i < n; i++)
			queue_pixel(pick_pixel(), (i == 0) ? restart : ($urandom_range(0, 99) == 0));
	endtask

	task automatic note_mismatch(input string what, input median_beat_t want,
			input median_beat_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected med=%0d col=%0d row=%0d last=%0b, got med=%0d col=%0d row=%0d last=%0b",
				$time, what, want.med, want.col, want.row, want.last,
				got.med, got.col, got.row, got.last);
	endtask

	// Track pixel beats taken by the block and run them through the window
	always @(posedge clk) begin
		pix_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			advance_window(pixel_value, frame_start);
			pixels_in++;
		end
		if (arst_n && in_valid && in_stall)
			backpressure++;
		cyc++;
	end

	// Drive pixel beats; hold a stalled beat, idle at random
	always @(negedge clk) begin
		if (arst_n && (!in_valid || pix_taken)) begin
			if (pixel_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				next_beat = pixel_backlog.pop_front();
				in_valid    <= 1'b1;
				pixel_value <= next_beat.pix;
				frame_start <= next_beat.fs;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: random, plus a long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (holds_done < 2 && medians_seen >= 100 + 300*holds_done &&
					pixel_backlog.size() > 20) begin
				hold_left  <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
			end
			out_stall <= (hold_left > 0) || (!calm && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Check each median beat against the oldest expectation
	always @(posedge clk) begin
		median_beat_t got, want;
		got.med  = median_value;
		got.col  = out_col;
		got.row  = out_row;
		got.last = frame_last;
		if (arst_n && out_valid && !out_stall) begin
			medians_seen++;
			if (frame_last === 1'b1)
				frame_ends++;
			if (pending_medians.size() == 0) begin
				want = '0;
				note_mismatch("unexpected median beat", want, got);
			end else begin
				want = pending_medians.pop_front();
				if (got.med !== want.med || got.col !== want.col ||
						got.row !== want.row || got.last !== want.last)
					note_mismatch("median beat mismatch", want, got);
			end
		end
	end

	// Watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck <= 0;
			else
				stuck <= stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("Timeout: no beat for %0d cycles", STUCK_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] lw, fr;
		int unsigned fw, fh, sel;
		int n, random_items;
		bit wide_done, restart;

		for (int i = 0; i < (WIN-1)*MAX_WIDTH_DEF; i++)
			line_mem[i] = '0;
		for (int i = 0; i < WIN*WIN; i++)
			win_px[i] = '0;
		col_pos        = 0;
		row_pos        = 0;
		cfg_line_width = LINE_REG_W'(LINE_WIDTH_RST);
		cfg_frame_rows = ROWS_W'(FRAME_ROWS_RST);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: smallest sizes (zero saturates up), extreme pixels, frame wrap
		run_phase(13'd0, 13'd0, 0, 1'b0);
		queue_pixel(8'h00, 1'b1);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'h00, 1'b0);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'h00, 1'b0);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'h00, 1'b0);
		queue_pixel(8'h80, 1'b0);
		// next frame with no start mark: counters wrapped at end of frame
		for (int i = 0; i < 9; i++)
			queue_pixel((i % 2) ? 8'h55 : 8'hAA, 1'b0);
		// restart in the middle of a row
		queue_pixel(8'h01, 1'b1);
		queue_pixel(8'h02, 1'b0);
		queue_pixel(8'h7F, 1'b1);
		queue_pixel(8'hFE, 1'b0);

		// Random: mostly whole frames of small sizes, some lowered mid-frame
		random_items = 0;
		wide_done    = 1'b0;
		while (random_items < RANDOM_ITEMS) begin
			if (!wide_done && random_items >= RANDOM_ITEMS/2) begin
				// widest line, saturated from the register maximum, rows saturated up;
				// a following phase may carry on from a column past its own width
				run_phase(13'h0FFF, 13'd2, WIDE_ITEMS, 1'b1);
				random_items += WIDE_ITEMS;
				wide_done = 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 70)
				lw = CFG_DATA_W'($urandom_range(3, 16));
			else if (sel < 85)
				lw = CFG_DATA_W'($urandom_range(17, 64));
			else if (sel < 92)
				lw = CFG_DATA_W'($urandom_range(0, 2));
			else
				// top bit lies above the register
				lw = CFG_DATA_W'(32'h1000 | $urandom_range(3, 16));
			sel = $urandom_range(0, 99);
			if (sel < 70)
				fr = CFG_DATA_W'($urandom_range(3, 6));
			else if (sel < 85)
				fr = CFG_DATA_W'($urandom_range(7, 20));
			else if (sel < 93)
				fr = CFG_DATA_W'($urandom_range(0, 2));
			else
				fr = CFG_DATA_W'($urandom_range(ROW_LIMIT, 8191));
			fw = sat_width(lw[LINE_REG_W-1:0]);
			fh = sat_rows(fr[ROWS_W-1:0]);
			if (fh > 8)
				fh = 8;
			// a wider line needs a fresh frame so no unwritten column is read
			restart = (fw > sat_width(cfg_line_width)) || ($urandom_range(0, 3) != 0);
			n = fw * fh * $urandom_range(1, 2) + $urandom_range(0, fw);
			if (n > 400)
				n = $urandom_range(200, 400);
			run_phase(lw, fr, n, restart);
			random_items += n;
		end

		settle();
		$display("Run covered %0d pixel beats, %0d median beats, %0d frame ends, %0d register writes",
			pixels_in, medians_seen, frame_ends, cfg_writes);
		$display("Input stalled on %0d cycles over %0d receiver hold-offs; %0d mismatches",
			backpressure, holds_done, mismatches);
		if (mismatches == 0 && pending_medians.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mf2d_pkg.sv
rtl/core/mf2d_front.sv
rtl/core/mf2d_queue.sv
rtl/core/mf2d_window.sv
rtl/core/mf2d_median.sv
rtl/core/median_filter_2d.sv
tb/sv/tb_median_filter_2d.sv
